@@ hw/rtl/modbus_rtu_read_master_defines.svh @@
// assertion macros used by the top-level rtl file
`ifndef MODBUS_RTU_READ_MASTER_DEFINES_SVH
`define MODBUS_RTU_READ_MASTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MBRM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define MBRM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/mbrm_pkg.sv @@
// shared constants and codes of the modbus rtu read master
package mbrm_pkg;
    localparam int OP_W   = 3;
    localparam int DATA_W = 120;

    localparam logic [OP_W-1:0] OP_RX      = 3'd0;
    localparam logic [OP_W-1:0] OP_PARSE   = 3'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd2;
    localparam logic [OP_W-1:0] OP_SEND    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_TX     = 1'b1;

    localparam logic [1:0] REG_SLAVE_ID  = 2'd0;
    localparam logic [1:0] REG_USE_INPUT = 2'd1;
    localparam logic [1:0] REG_START     = 2'd2;

    localparam logic [7:0]  FN_HOLDING  = 8'h03;
    localparam logic [7:0]  FN_INPUT    = 8'h04;
    localparam logic [7:0]  EXC_FLAG    = 8'h80;
    localparam logic [7:0]  BYTE_COUNT  = 8'h04;
    localparam logic [7:0]  MAX_SLAVE   = 8'd247;
    localparam logic [15:0] MAX_START   = 16'd65533;
    localparam logic [15:0] REG_COUNT   = 16'd2;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
endpackage

@@ hw/rtl/mbrm_ram.sv @@
// generic single-port-write ram with registered read
module mbrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/mbrm_crc.sv @@
// crc-16/modbus accumulator, one byte per cycle while en is high
module mbrm_crc
    import mbrm_pkg::*;
(
    input  logic        aclk,
    input  logic        init,
    input  logic        en,
    input  logic [7:0]  din,
    output logic [15:0] crc
);
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb begin
        crc_next = crc_reg ^ {8'h00, din};
        for (int b = 0; b < 8; b++) begin
            if (crc_next[0]) begin
                crc_next = (crc_next >> 1) ^ CRC_POLY;
            end else begin
                crc_next = crc_next >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (init) begin
            crc_reg <= CRC_INIT;
        end else if (en) begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;
endmodule

@@ hw/rtl/modbus_rtu_read_master.sv @@
// top level of the modbus rtu read master: sequencer, rx buffer and output register
//
// usage
//   s_ channel: one item per operation; s_tuser[2:0] is the operation (received
//   byte, end of chunk parse, empty read timeout, send request, clear counters),
//   s_tdata[7:0] the received byte. s_tready is high only while idle.
//   m_ channel: status items (tuser 0) for parse and timeout, eight transmit
//   items (tuser 1) for a send request; tlast marks the last item of an operation.
//   cfg_ channel: register writes (slave id, function select, start register),
//   taken while idle.
// sequencing
//   received byte and clear counters complete in the idle state. timeout: the
//   status item is loaded in state LOAD and then held in state STAT.
//   parse: the sequencer reads the rx buffer one byte at a time, a read state
//   then an evaluate state per byte, through one ram read port and one shared
//   crc unit; a resync scan steps check, read and evaluate states per byte.
//   send request: a load state then a wait state per transmit item.
// reset clears counters and fill count; config goes to slave id 1, fn 03, start 0.
// when the receiver stalls the item holds in the output register and no
// new input item is taken until it is delivered.
module modbus_rtu_read_master
    import mbrm_pkg::*;
#(
    parameter int RX_BUFFER_DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input item channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // rx_byte
    input  logic [OP_W-1:0]   s_tuser,   // operation
    // result item channel
    output logic              m_tvalid,
    input  logic              m_tready,
    // tx_byte, angle_valid, angle_x, angle_y, exception_code, good_frames,
    // bad_frames, crc_error_event, timeout_event, frame_ok_event, zero pad
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tuser,   // result_kind
    output logic              m_tlast,   // last_item
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    localparam int AW = $clog2(RX_BUFFER_DEPTH);
    localparam int CW = $clog2(RX_BUFFER_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PCHK, S_PRD, S_PEV, S_RCHK, S_RRD, S_REV,
        S_LOAD, S_STAT, S_TX, S_TXW
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   head_reg;
    logic [CW-1:0]   idx_reg;
    logic [7:0]      slave_id_reg;
    logic            use_input_reg;
    logic [15:0]     start_reg;
    logic [7:0]      last_exc_reg;
    logic [31:0]     ok_count_reg;
    logic [31:0]     bad_count_reg;
    logic            bad_noted_reg;
    logic            ev_crc_reg;
    logic            ev_to_reg;
    logic            ev_ok_reg;
    logic            valid_reg;
    logic            exc_reg;
    logic [7:0]      exc_code_reg;
    logic [7:0]      crc_lo_reg;
    logic [15:0]     ax_reg;
    logic [15:0]     ay_reg;
    logic            m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic            m_tuser_reg;
    logic            m_tlast_reg;

    logic [7:0]      fn;
    logic [7:0]      rdata;
    logic [AW-1:0]   raddr;
    logic [AW-1:0]   waddr;
    logic            we;
    logic            in_acc;
    logic            byte_match;
    logic            buf_full;
    logic [CW-1:0]   body;
    logic [15:0]     crc;
    logic            crc_init;
    logic            crc_en;
    logic [7:0]      crc_din;
    logic [7:0]      tx_q;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(off);
        if (sum >= (AW+1)'(RX_BUFFER_DEPTH)) begin
            sum = sum - (AW+1)'(RX_BUFFER_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign fn         = use_input_reg ? FN_INPUT : FN_HOLDING;
    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign byte_match = (s_tdata == slave_id_reg);
    assign buf_full   = (count_reg == CW'(RX_BUFFER_DEPTH));
    assign raddr      = wrap_add(head_reg, idx_reg);
    assign waddr      = buf_full ? head_reg : wrap_add(head_reg, count_reg);
    assign we         = in_acc && (s_tuser == OP_RX)
                        && (byte_match || ((count_reg != '0) && !buf_full));
    // crc body length: three bytes for an exception reply, seven for data
    assign body       = exc_reg ? CW'(3) : CW'(7);

    // request frame byte for the current transmit index
    always_comb begin
        unique case (idx_reg[2:0])
            3'd0:    tx_q = slave_id_reg;
            3'd1:    tx_q = fn;
            3'd2:    tx_q = start_reg[15:8];
            3'd3:    tx_q = start_reg[7:0];
            3'd4:    tx_q = REG_COUNT[15:8];
            3'd5:    tx_q = REG_COUNT[7:0];
            3'd6:    tx_q = crc[7:0];
            default: tx_q = crc[15:8];
        endcase
    end

    // shared crc unit feeds from the buffer walk or the request bytes
    assign crc_init = (state_reg == S_PCHK) || (in_acc && (s_tuser == OP_SEND));
    assign crc_en   = ((state_reg == S_PEV) && (idx_reg < body))
                      || ((state_reg == S_TX) && (idx_reg < CW'(6)));
    assign crc_din  = (state_reg == S_TX) ? tx_q : rdata;

    mbrm_ram #(
        .WIDTH(8),
        .DEPTH(RX_BUFFER_DEPTH)
    ) u_rx_buf (
        .clk  (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(s_tdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    mbrm_crc u_crc (
        .aclk(aclk),
        .init(crc_init),
        .en  (crc_en),
        .din (crc_din),
        .crc (crc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            slave_id_reg  <= 8'd1;
            use_input_reg <= 1'b0;
            start_reg     <= '0;
            last_exc_reg  <= '0;
            ok_count_reg  <= '0;
            bad_count_reg <= '0;
            bad_noted_reg <= 1'b0;
            exc_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        ev_crc_reg <= 1'b0;
                        ev_to_reg  <= 1'b0;
                        ev_ok_reg  <= 1'b0;
                        valid_reg  <= 1'b0;
                        idx_reg    <= '0;
                        priority case (s_tuser)
                            OP_RX: begin
                                if (buf_full) begin
                                    count_reg <= byte_match ? CW'(1) : '0;
                                end else if (we) begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            OP_PARSE: begin
                                bad_noted_reg <= 1'b0;
                                state_reg     <= S_PCHK;
                            end
                            OP_TIMEOUT: begin
                                // a held partial frame is dropped as bad
                                bad_noted_reg <= (count_reg != '0);
                                if (count_reg != '0) begin
                                    bad_count_reg <= bad_count_reg + 32'd1;
                                    ev_to_reg     <= 1'b1;
                                end
                                count_reg <= '0;
                                state_reg <= S_LOAD;
                            end
                            OP_SEND: begin
                                count_reg    <= '0;
                                last_exc_reg <= '0;
                                state_reg    <= S_TX;
                            end
                            OP_CLEAR: begin
                                ok_count_reg  <= '0;
                                bad_count_reg <= '0;
                                count_reg     <= '0;
                                last_exc_reg  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (cfg_valid) begin
                        // rejected values leave buffer and exception untouched
                        priority case (cfg_index)
                            REG_SLAVE_ID: begin
                                if (cfg_data[7:0] != 8'd0 && cfg_data[7:0] <= MAX_SLAVE) begin
                                    slave_id_reg <= cfg_data[7:0];
                                    count_reg    <= '0;
                                    last_exc_reg <= '0;
                                end
                            end
                            REG_USE_INPUT: begin
                                use_input_reg <= cfg_data[0];
                                count_reg     <= '0;
                                last_exc_reg  <= '0;
                            end
                            REG_START: begin
                                if (cfg_data <= MAX_START) begin
                                    start_reg    <= cfg_data;
                                    count_reg    <= '0;
                                    last_exc_reg <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PCHK: begin
                    idx_reg   <= '0;
                    state_reg <= (count_reg < CW'(2)) ? S_LOAD : S_PRD;
                end
                S_PRD: begin
                    state_reg <= S_PEV;
                end
                S_PEV: begin
                    state_reg <= S_PRD;
                    idx_reg   <= idx_reg + CW'(1);
                    if (idx_reg == CW'(0)) begin
                        if (rdata != slave_id_reg) begin
                            idx_reg   <= CW'(1);
                            state_reg <= S_RCHK;
                        end
                    end else if (idx_reg == CW'(1)) begin
                        if (rdata == (fn | EXC_FLAG)) begin
                            exc_reg <= 1'b1;
                            if (count_reg < CW'(5)) begin
                                state_reg <= S_LOAD;
                            end
                        end else if (rdata != fn) begin
                            if (!bad_noted_reg) begin
                                bad_noted_reg <= 1'b1;
                                bad_count_reg <= bad_count_reg + 32'd1;
                                ev_to_reg     <= 1'b1;
                            end
                            idx_reg   <= CW'(1);
                            state_reg <= S_RCHK;
                        end else begin
                            exc_reg <= 1'b0;
                            if (count_reg < CW'(3)) begin
                                state_reg <= S_LOAD;
                            end
                        end
                    end else if (idx_reg == CW'(2) && !exc_reg) begin
                        if (rdata != BYTE_COUNT) begin
                            if (!bad_noted_reg) begin
                                bad_noted_reg <= 1'b1;
                                bad_count_reg <= bad_count_reg + 32'd1;
                                ev_to_reg     <= 1'b1;
                            end
                            idx_reg   <= CW'(1);
                            state_reg <= S_RCHK;
                        end else if (count_reg < CW'(9)) begin
                            state_reg <= S_LOAD;
                        end
                    end else if (idx_reg < body) begin
                        // byte two holds an exception code; bytes three to six carry the two registers
                        unique case (idx_reg[2:0])
                            3'd2:    exc_code_reg <= rdata;
                            3'd3:    ax_reg[15:8] <= rdata;
                            3'd4:    ax_reg[7:0]  <= rdata;
                            3'd5:    ay_reg[15:8] <= rdata;
                            3'd6:    ay_reg[7:0]  <= rdata;
                            default: begin
                            end
                        endcase
                    end else if (idx_reg == body) begin
                        crc_lo_reg <= rdata;
                    end else begin
                        if ({rdata, crc_lo_reg} != crc) begin
                            if (!bad_noted_reg) begin
                                bad_noted_reg <= 1'b1;
                                bad_count_reg <= bad_count_reg + 32'd1;
                                ev_crc_reg    <= 1'b1;
                            end
                            idx_reg   <= CW'(1);
                            state_reg <= S_RCHK;
                        end else begin
                            // good frame: drop it from the buffer front
                            head_reg  <= wrap_add(head_reg, idx_reg + CW'(1));
                            count_reg <= count_reg - (idx_reg + CW'(1));
                            ev_ok_reg <= 1'b1;
                            state_reg <= S_LOAD;
                            if (exc_reg) begin
                                last_exc_reg <= exc_code_reg;
                                if (!bad_noted_reg) begin
                                    bad_noted_reg <= 1'b1;
                                    bad_count_reg <= bad_count_reg + 32'd1;
                                end
                            end else begin
                                last_exc_reg <= '0;
                                ok_count_reg <= ok_count_reg + 32'd1;
                                valid_reg    <= 1'b1;
                            end
                        end
                    end
                end
                S_RCHK: begin
                    // scan for the next slave id byte past the front
                    if (idx_reg >= count_reg) begin
                        count_reg <= '0;
                        state_reg <= S_PCHK;
                    end else begin
                        state_reg <= S_RRD;
                    end
                end
                S_RRD: begin
                    state_reg <= S_REV;
                end
                S_REV: begin
                    if (rdata == slave_id_reg) begin
                        head_reg  <= wrap_add(head_reg, idx_reg);
                        count_reg <= count_reg - idx_reg;
                        state_reg <= S_PCHK;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_RCHK;
                    end
                end
                S_LOAD: begin
                    m_tvalid_reg <= 1'b1;
                    m_tuser_reg  <= KIND_STATUS;
                    m_tlast_reg  <= 1'b1;
                    m_tdata_reg  <= {4'd0, ev_ok_reg, ev_to_reg, ev_crc_reg,
                                     bad_count_reg, ok_count_reg, last_exc_reg,
                                     valid_reg ? ay_reg : 16'd0,
                                     valid_reg ? ax_reg : 16'd0,
                                     valid_reg, 8'd0};
                    state_reg    <= S_STAT;
                end
                S_STAT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_TX: begin
                    m_tvalid_reg <= 1'b1;
                    m_tuser_reg  <= KIND_TX;
                    m_tlast_reg  <= (idx_reg == CW'(7));
                    m_tdata_reg  <= {(DATA_W-8)'(0), tx_q};
                    state_reg    <= S_TXW;
                end
                S_TXW: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        idx_reg      <= idx_reg + CW'(1);
                        state_reg    <= (idx_reg == CW'(7)) ? S_IDLE : S_TX;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`include "modbus_rtu_read_master_defines.svh"

    `MBRM_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    `MBRM_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(RX_BUFFER_DEPTH))
    `MBRM_ASSERT_IMPL(a_tx_clean, aclk, aresetn, m_tvalid && (m_tuser == KIND_TX),
                      m_tdata[DATA_W-1:8] == '0)
    `MBRM_ASSERT_NEXT(a_tx_end, aclk, aresetn, (state_reg == S_TXW) && m_tready && (idx_reg == CW'(7)), s_tready)
endmodule
